// ===== hdl/bdfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bracketed decimal frame parser.
// No dependencies.
package bdfp_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_SEP   = 8'h2C;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int NUM_FIELDS = 5;
  localparam int NUM_DIST   = 4;
  localparam int IDX_W      = 4;
  localparam int OUT_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int RESULT_W   = NUM_DIST * OUT_W + 1 + IDX_W;
  localparam int TDATA_W    = ((RESULT_W + 7) / 8) * 8;
  localparam int PAD_W      = TDATA_W - RESULT_W;

  typedef logic [IDX_W-1:0] field_idx_t;

  localparam field_idx_t IDX_MAX = '1;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

endpackage

// ===== hdl/bdfp_parse.sv =====
`timescale 1ns / 1ps
// Input register, frame and field tracking, on-the-fly decimal conversion,
// and the field snapshot taken at each closing bracket. Uses bdfp_pkg.
module bdfp_parse #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bdfp_pkg::BYTE_W-1:0] in_byte,
  output logic                       snap_valid,
  input  logic                       snap_ready,
  output logic [VALUE_WIDTH-1:0]     snap_vals [bdfp_pkg::NUM_FIELDS],
  output bdfp_pkg::field_idx_t       snap_count
);

  logic                          iv;
  logic [bdfp_pkg::BYTE_W-1:0]   ib;
  logic                          in_frame;
  logic                          in_frame_next;
  bdfp_pkg::field_idx_t          field_index;
  bdfp_pkg::field_idx_t          field_index_next;
  bdfp_pkg::phase_t              phase;
  bdfp_pkg::phase_t              phase_next;
  logic                          negative;
  logic                          negative_next;
  logic [VALUE_WIDTH-1:0]        accumulator;
  logic [VALUE_WIDTH-1:0]        accumulator_next;
  logic [VALUE_WIDTH-1:0]        field_values [bdfp_pkg::NUM_FIELDS];

  logic                   is_open, is_sep, is_close, is_digit, is_ws, is_sign;
  logic                   sep_hit, close_hit, snap_free, parse_go, close_go, end_go;
  logic [VALUE_WIDTH-1:0] digit_val, acc_x10, store_val;

  assign is_open  = (ib == bdfp_pkg::CH_OPEN);
  assign is_sep   = (ib == bdfp_pkg::CH_SEP);
  assign is_close = (ib == bdfp_pkg::CH_CLOSE);
  assign is_digit = (ib >= bdfp_pkg::CH_ZERO) && (ib <= bdfp_pkg::CH_NINE);
  assign is_ws    = (ib == bdfp_pkg::CH_SPACE) ||
                    ((ib >= bdfp_pkg::CH_TAB) && (ib <= bdfp_pkg::CH_CR));
  assign is_sign  = (ib == bdfp_pkg::CH_PLUS) || (ib == bdfp_pkg::CH_MINUS);

  assign sep_hit   = in_frame && is_sep;
  assign close_hit = in_frame && is_close;
  assign snap_free = !snap_valid || snap_ready;
  assign parse_go  = iv && (!close_hit || snap_free);
  assign in_ready  = !iv || parse_go;
  assign close_go  = parse_go && close_hit;
  assign end_go    = parse_go && (sep_hit || close_hit);

  assign digit_val = VALUE_WIDTH'(ib[3:0]);
  assign acc_x10   = (accumulator << 3) + (accumulator << 1) + digit_val;
  assign store_val = negative ? (~accumulator + 1'b1) : accumulator;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib <= in_byte;
    end
  end

  // Conversion phase: next state
  always_comb begin
    phase_next = phase;
    if (is_open || sep_hit || close_hit) begin
      phase_next = bdfp_pkg::PH_SKIP;
    end else if (in_frame) begin
      unique case (phase)
        bdfp_pkg::PH_SKIP: begin
          priority if (is_ws) begin
            phase_next = bdfp_pkg::PH_SKIP;
          end else if (is_sign) begin
            phase_next = bdfp_pkg::PH_SIGN;
          end else if (is_digit) begin
            phase_next = bdfp_pkg::PH_DIGITS;
          end else begin
            phase_next = bdfp_pkg::PH_DONE;
          end
        end
        bdfp_pkg::PH_SIGN, bdfp_pkg::PH_DIGITS: begin
          phase_next = is_digit ? bdfp_pkg::PH_DIGITS : bdfp_pkg::PH_DONE;
        end
        bdfp_pkg::PH_DONE: begin
          phase_next = bdfp_pkg::PH_DONE;
        end
        default: begin
          phase_next = bdfp_pkg::PH_DONE;
        end
      endcase
    end
  end

  // Conversion datapath and frame tracking
  always_comb begin
    negative_next    = negative;
    accumulator_next = accumulator;
    in_frame_next    = in_frame;
    field_index_next = field_index;
    priority if (is_open) begin
      negative_next    = 1'b0;
      accumulator_next = '0;
      in_frame_next    = 1'b1;
      field_index_next = '0;
    end else if (close_hit) begin
      negative_next    = 1'b0;
      accumulator_next = '0;
      in_frame_next    = 1'b0;
      field_index_next = '0;
    end else if (sep_hit) begin
      negative_next    = 1'b0;
      accumulator_next = '0;
      if (field_index != bdfp_pkg::IDX_MAX) begin
        field_index_next = field_index + 1'b1;
      end
    end else if (in_frame) begin
      unique case (phase)
        bdfp_pkg::PH_SKIP: begin
          if (is_sign) begin
            negative_next = (ib == bdfp_pkg::CH_MINUS);
          end else if (is_digit && !is_ws) begin
            accumulator_next = digit_val;
          end
        end
        bdfp_pkg::PH_SIGN, bdfp_pkg::PH_DIGITS: begin
          if (is_digit) begin
            accumulator_next = acc_x10;
          end
        end
        bdfp_pkg::PH_DONE: begin
          accumulator_next = accumulator;
        end
        default: begin
          accumulator_next = accumulator;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      field_index <= '0;
      phase       <= bdfp_pkg::PH_SKIP;
      negative    <= 1'b0;
      accumulator <= '0;
    end else if (parse_go) begin
      in_frame    <= in_frame_next;
      field_index <= field_index_next;
      phase       <= phase_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
    end
  end

  // Stored field values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bdfp_pkg::NUM_FIELDS; i++) begin
        field_values[i] <= '0;
      end
    end else if (end_go) begin
      for (int i = 0; i < bdfp_pkg::NUM_FIELDS; i++) begin
        if (field_index == bdfp_pkg::IDX_W'(i)) begin
          field_values[i] <= store_val;
        end
      end
    end
  end

  // Snapshot at closing bracket
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_free) begin
      snap_valid <= close_go;
    end
  end

  always_ff @(posedge clk) begin
    if (close_go) begin
      for (int i = 0; i < bdfp_pkg::NUM_FIELDS; i++) begin
        snap_vals[i] <= (field_index == bdfp_pkg::IDX_W'(i)) ? store_val : field_values[i];
      end
      snap_count <= (field_index == bdfp_pkg::IDX_MAX) ? bdfp_pkg::IDX_MAX
                                                       : field_index + 1'b1;
    end
  end

  a_close_ends_frame: assert property (@(posedge clk) disable iff (rst)
    close_go |=> !in_frame && (field_index == '0) && (phase == bdfp_pkg::PH_SKIP))
    else $error("frame state not cleared after close");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (field_index == '0))
    else $error("field index nonzero outside a frame");

  a_close_snapshot: assert property (@(posedge clk) disable iff (rst)
    close_go |=> snap_valid)
    else $error("close byte did not produce a snapshot");

endmodule

// ===== hdl/bdfp_check.sv =====
`timescale 1ns / 1ps
// Sum check stages: partial sums, compare against the fifth field, distance
// latch, and the output register. Uses bdfp_pkg.
module bdfp_check #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         snap_valid,
  output logic                         snap_ready,
  input  logic [VALUE_WIDTH-1:0]       snap_vals [bdfp_pkg::NUM_FIELDS],
  input  bdfp_pkg::field_idx_t         snap_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bdfp_pkg::TDATA_W-1:0] out_data
);

  logic                   cv;
  logic [VALUE_WIDTH-1:0] s01, s23;
  logic [VALUE_WIDTH-1:0] cvals [bdfp_pkg::NUM_FIELDS];
  bdfp_pkg::field_idx_t   ccount;
  logic [VALUE_WIDTH-1:0] distances [bdfp_pkg::NUM_DIST];
  logic [VALUE_WIDTH-1:0] distances_next [bdfp_pkg::NUM_DIST];
  logic [VALUE_WIDTH-1:0] sum_all;
  logic                   ok, c_ready, out_free, out_load;

  assign out_free   = !out_valid || out_ready;
  assign c_ready    = !cv || out_free;
  assign snap_ready = c_ready;
  assign out_load   = cv && out_free;

  // Partial sums
  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (c_ready) begin
      cv <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && c_ready) begin
      s01    <= snap_vals[0] + snap_vals[1];
      s23    <= snap_vals[2] + snap_vals[3];
      cvals  <= snap_vals;
      ccount <= snap_count;
    end
  end

  assign sum_all = s01 + s23;
  assign ok      = (sum_all == cvals[bdfp_pkg::NUM_DIST]);

  always_comb begin
    for (int i = 0; i < bdfp_pkg::NUM_DIST; i++) begin
      distances_next[i] = ok ? cvals[i] : distances[i];
    end
  end

  // Distance latch and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bdfp_pkg::NUM_DIST; i++) begin
        distances[i] <= '0;
      end
    end else if (out_load) begin
      distances <= distances_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {{bdfp_pkg::PAD_W{1'b0}}, ccount, ok,
                   bdfp_pkg::OUT_W'($signed(distances_next[3])),
                   bdfp_pkg::OUT_W'($signed(distances_next[2])),
                   bdfp_pkg::OUT_W'($signed(distances_next[1])),
                   bdfp_pkg::OUT_W'($signed(distances_next[0]))};
    end
  end

  a_mismatch_holds_dist: assert property (@(posedge clk) disable iff (rst)
    (out_load && !ok) |=> $stable(distances[0]) && $stable(distances[1]) &&
                          $stable(distances[2]) && $stable(distances[3]))
    else $error("distances changed on sum mismatch");

  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result lost at output register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (cv && !out_free) |=> cv && $stable(s01) && $stable(s23))
    else $error("sum stage changed while stalled");

endmodule

// ===== hdl/bracketed_decimal_frame_parser_top.sv =====
`timescale 1ns / 1ps
// Top level of the bracketed decimal frame parser. Uses bdfp_pkg, bdfp_parse, bdfp_check.
// Throughput: one byte per cycle; a closing bracket stalls only while the snapshot,
//   partial-sum and output registers all hold results the output side has not taken.
// Result path: the closing bracket passes the input register, the snapshot, the partial
//   sums and the compare into the output register before the result transfer is offered.
// Reset: synchronous; clears frame state, stored fields and distances.
module bracketed_decimal_frame_parser_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bdfp_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [31:0] dist_a, [63:32] dist_b, [95:64] dist_c, [127:96] dist_d,
  // [128] sum_ok, [132:129] fields_seen, [135:133] zero
  output logic [bdfp_pkg::TDATA_W-1:0] m_axis_tdata
);

  logic                   snap_valid;
  logic                   snap_ready;
  logic [VALUE_WIDTH-1:0] snap_vals [bdfp_pkg::NUM_FIELDS];
  bdfp_pkg::field_idx_t   snap_count;

  bdfp_parse #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_vals  (snap_vals),
    .snap_count (snap_count)
  );

  bdfp_check #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_vals  (snap_vals),
    .snap_count (snap_count),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule

// ===== tb/bdfp_frame_checker.sv =====
`timescale 1ns / 1ps
// Frame result checker for the bracketed decimal frame parser: watches both
// stream channels, predicts each closing-bracket result and compares it.
// Depends on bdfp_pkg.
module bdfp_frame_checker
  import bdfp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [BYTE_W-1:0]   s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [TDATA_W-1:0]  m_axis_tdata,
  output int                  error_count,
  output int                  frames_pending
);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic [IDX_W-1:0] fields_seen;
    logic             sum_ok;
    logic [OUT_W-1:0] dist_d;
    logic [OUT_W-1:0] dist_c;
    logic [OUT_W-1:0] dist_b;
    logic [OUT_W-1:0] dist_a;
  } frame_result_t;

  logic            open_frame;
  field_idx_t      field_num;
  phase_t          phase;
  logic            neg;
  value_t          acc;
  value_t          stored [NUM_FIELDS];
  value_t          distances [NUM_DIST];
  frame_result_t   expected_frames [$];
  int              mismatch_total = 0;

  function automatic logic [OUT_W-1:0] to_out(input value_t v);
    logic signed [63:0] wide;
    wide = $signed(v);
    return wide[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    mismatch_total++;
  endtask

  task automatic restart_field();
    phase = PH_SKIP;
    neg   = 1'b0;
    acc   = '0;
  endtask

  task automatic store_field();
    value_t v;
    v = neg ? value_t'(-acc) : acc;
    if (field_num < NUM_FIELDS) stored[field_num] = v;
  endtask

  task automatic parse_byte(input logic [7:0] c);
    logic          is_digit;
    logic          is_space;
    value_t        total;
    frame_result_t r;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    if (c == CH_OPEN) begin
      open_frame = 1'b1;
      field_num  = '0;
      restart_field();
    end else if (!open_frame) begin
    end else if (c == CH_SEP) begin
      store_field();
      if (field_num != IDX_MAX) field_num = field_num + 1'b1;
      restart_field();
    end else if (c == CH_CLOSE) begin
      store_field();
      total = stored[0] + stored[1] + stored[2] + stored[3];
      r.sum_ok = (total == stored[4]);
      if (r.sum_ok) begin
        for (int i = 0; i < NUM_DIST; i++) distances[i] = stored[i];
      end
      r.dist_a = to_out(distances[0]);
      r.dist_b = to_out(distances[1]);
      r.dist_c = to_out(distances[2]);
      r.dist_d = to_out(distances[3]);
      r.fields_seen = (field_num == IDX_MAX) ? IDX_MAX : field_num + 1'b1;
      expected_frames.push_back(r);
      open_frame = 1'b0;
      field_num  = '0;
      restart_field();
    end else begin
      case (phase)
        PH_SKIP: begin
          if (is_space) begin
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            neg   = (c == CH_MINUS);
            phase = PH_SIGN;
          end else if (is_digit) begin
            acc   = value_t'(c - CH_ZERO);
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit) begin
            acc   = value_t'(acc * 10 + (c - CH_ZERO));
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst) begin
      open_frame = 1'b0;
      field_num  = '0;
      restart_field();
      for (int i = 0; i < NUM_FIELDS; i++) stored[i] = '0;
      for (int i = 0; i < NUM_DIST; i++) distances[i] = '0;
      expected_frames.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = frame_result_t'(m_axis_tdata[RESULT_W-1:0]);
        if (expected_frames.size() == 0) begin
          report_mismatch("result transfer with no frame pending", got.dist_a, '0);
        end else begin
          want = expected_frames.pop_front();
          if (got.dist_a !== want.dist_a) report_mismatch("dist_a", got.dist_a, want.dist_a);
          if (got.dist_b !== want.dist_b) report_mismatch("dist_b", got.dist_b, want.dist_b);
          if (got.dist_c !== want.dist_c) report_mismatch("dist_c", got.dist_c, want.dist_c);
          if (got.dist_d !== want.dist_d) report_mismatch("dist_d", got.dist_d, want.dist_d);
          if (got.sum_ok !== want.sum_ok) report_mismatch("sum_ok", got.sum_ok, want.sum_ok);
          if (got.fields_seen !== want.fields_seen) begin
            report_mismatch("fields_seen", got.fields_seen, want.fields_seen);
          end
        end
      end
    end
    error_count    <= mismatch_total;
    frames_pending <= expected_frames.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the bracketed decimal frame parser: drives byte frames
// and noise under several idle/stall mixes and gives the verdict.
// Depends on bdfp_pkg, bracketed_decimal_frame_parser_top, bdfp_frame_checker.
module tb;
  import bdfp_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [BYTE_W-1:0]  s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;

  int error_count;
  int frames_pending;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int bytes_sent = 0;

  logic [7:0] outgoing_bytes [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bracketed_decimal_frame_parser_top #(
    .VALUE_WIDTH(32)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bdfp_frame_checker #(
    .VALUE_WIDTH(32)
  ) u_frame_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .error_count    (error_count),
    .frames_pending (frames_pending)
  );

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_queued();
    foreach (outgoing_bytes[i]) send_byte(outgoing_bytes[i]);
    outgoing_bytes.delete();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) outgoing_bytes.push_back(s[i]);
  endtask

  function automatic logic [31:0] pick_value();
    int k;
    k = $urandom_range(99999);
    case ($urandom_range(5))
      0: return 32'($urandom_range(40)) - 32'd20;
      1: return $urandom;
      2: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      3: return 32'(k);
      default: return 32'(-k);
    endcase
  endfunction

  task automatic push_field(input logic [31:0] v, input bit faithful);
    int         mode;
    int         k;
    logic [7:0] junk;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        k = $urandom_range(5);
        outgoing_bytes.push_back((k == 5) ? CH_SPACE : CH_TAB + 8'(k));
      end
    end
    mode = faithful ? $urandom_range(2) : $urandom_range(5);
    case (mode)
      0: push_text($sformatf("%0d", $signed(v)));
      1: begin
        outgoing_bytes.push_back(CH_PLUS);
        push_text($sformatf("%0d", v));
      end
      2: push_text($sformatf("%0d", v));
      3: begin
      end
      4: begin
        repeat ($urandom_range(10, 13)) begin
          outgoing_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
      end
      default: outgoing_bytes.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
    endcase
    if (!faithful && $urandom_range(2) == 0) begin
      junk = 8'($urandom_range(255));
      if (junk == CH_OPEN || junk == CH_SEP || junk == CH_CLOSE) junk = 8'h00;
      outgoing_bytes.push_back(junk);
      if ($urandom_range(1)) outgoing_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
  endtask

  task automatic send_frame();
    int          kind;
    int          nf;
    bit          faithful;
    logic [31:0] vals [NUM_FIELDS];
    kind     = $urandom_range(99);
    faithful = (kind < 45);
    for (int i = 0; i < NUM_FIELDS; i++) vals[i] = pick_value();
    if (faithful) vals[4] = vals[0] + vals[1] + vals[2] + vals[3];
    if (kind < 60) nf = NUM_FIELDS;
    else if (kind < 85) nf = $urandom_range(1, 7);
    else if (kind < 93) nf = $urandom_range(14, 18);
    else nf = $urandom_range(1, 3);
    outgoing_bytes.push_back(CH_OPEN);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) outgoing_bytes.push_back(CH_SEP);
      push_field((i < NUM_FIELDS) ? vals[i] : pick_value(), faithful);
    end
    if (kind < 93) outgoing_bytes.push_back(CH_CLOSE);
    send_queued();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) outgoing_bytes.push_back(8'($urandom_range(255)));
    send_queued();
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int budget);
    int start_count;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    start_count    = bytes_sent;
    while (bytes_sent - start_count < budget) begin
      if ($urandom_range(9) < 3) send_noise();
      send_frame();
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    outgoing_bytes.push_back(CH_CLOSE);
    outgoing_bytes.push_back(CH_SEP);
    outgoing_bytes.push_back(8'hFF);
    outgoing_bytes.push_back(CH_OPEN);
    push_text("9");
    outgoing_bytes.push_back(CH_OPEN);
    push_text("1");
    outgoing_bytes.push_back(CH_SEP);
    push_text("-1");
    outgoing_bytes.push_back(CH_SEP);
    outgoing_bytes.push_back(CH_SEP);
    push_text("0");
    outgoing_bytes.push_back(8'h00);
    outgoing_bytes.push_back(CH_SPACE);
    push_text("7");
    outgoing_bytes.push_back(CH_SEP);
    push_text("0");
    outgoing_bytes.push_back(CH_CLOSE);
    outgoing_bytes.push_back(CH_OPEN);
    outgoing_bytes.push_back(CH_TAB);
    outgoing_bytes.push_back(CH_PLUS);
    push_text("9");
    outgoing_bytes.push_back(CH_CLOSE);
    send_queued();
    wait_drained();

    run_phase(0, 0, 500);
    run_phase(72, 0, 500);
    run_phase(0, 72, 500);
    run_phase(16, 16, 500);

    repeat (20) @(posedge clk);
    if (error_count == 0 && frames_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
